[hdl/marker_disc_letter_pixel_core_assert.svh]
// Assertion macros used by the checker file.
`ifndef MARKER_DISC_LETTER_PIXEL_CORE_ASSERT_SVH
`define MARKER_DISC_LETTER_PIXEL_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MDLP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("marker pixel core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MDLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("marker pixel core assertion failed");

`endif

[hdl/mdlp_pkg.sv]
`default_nettype none

package mdlp_pkg;

    localparam int COORD_BITS_DEFAULT = 8;
    localparam int ADDR_W = 5;

    localparam logic [7:0] SIZE_RESET = 8'd32;
    localparam logic [7:0] CODE_RESET = 8'd63;
    localparam logic [7:0] OPAQUE = 8'hFF;

    typedef enum logic [2:0] {
        REG_IMAGE_SIZE   = 3'd0,
        REG_LETTER_CODE  = 3'd1,
        REG_DISC_COLOR   = 3'd2,
        REG_RIM_COLOR    = 3'd3,
        REG_LETTER_COLOR = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
    } pixel_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } color_item_t;

    // Upper-case letters map to 0..25, digits to 26..35, anything else to the question mark.
    function automatic logic [5:0] glyph_index(input logic [7:0] code);
        logic [7:0] idx;
        idx = 8'd36;
        if (code >= 8'h41 && code <= 8'h5A)
        begin
            idx = code - 8'h41;
        end
        else if (code >= 8'h30 && code <= 8'h39)
        begin
            idx = code - 8'h30 + 8'd26;
        end
        return idx[5:0];
    endfunction

    // Seven rows of five bits, top row in the most significant position.
    function automatic logic [34:0] glyph_bitmap(input logic [5:0] idx);
        logic [34:0] r;
        case (idx)
            6'd0:    r = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            6'd1:    r = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            6'd2:    r = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            6'd3:    r = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            6'd4:    r = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            6'd5:    r = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            6'd6:    r = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
            6'd7:    r = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            6'd8:    r = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            6'd9:    r = {5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h0E};
            6'd10:   r = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            6'd11:   r = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            6'd12:   r = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            6'd13:   r = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            6'd14:   r = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            6'd15:   r = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            6'd16:   r = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            6'd17:   r = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            6'd18:   r = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            6'd19:   r = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            6'd20:   r = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            6'd21:   r = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            6'd22:   r = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
            6'd23:   r = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            6'd24:   r = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            6'd25:   r = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            6'd26:   r = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            6'd27:   r = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            6'd28:   r = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            6'd29:   r = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
            6'd30:   r = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            6'd31:   r = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
            6'd32:   r = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            6'd33:   r = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            6'd34:   r = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            6'd35:   r = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
            default: r = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/marker_disc_letter_pixel_core.sv]
// Marker pixel core: returns the RGBA color of one pixel of a square marker
// image, a disc with a rim band and a 5x7 character drawn over it.
// Pixel requests arrive on the pixel channel (pixel_valid, pixel_stall, pixel)
// and colors leave on the color channel (color_valid, color_stall, color).
// Each accepted item yields exactly one color item, in order.
// An accepted item passes four register stages: setup and scale, squares and
// glyph origin, distance and glyph cell, and the final color select in the
// output register, which drives color_valid.
// Throughput is one item per cycle while the receiver takes items.
// When color_stall holds a result, the stages behind it keep filling any empty
// slots, so the core still accepts items until every stage is occupied.
// Image size, letter code and the three colors are set through the APB-style
// port; write them only while no item is in flight.
// Reset empties the pipeline and sets the size to 32 and the letter to '?'
// with all colors black.
`default_nettype none

module marker_disc_letter_pixel_core #(
    parameter int COORD_BITS = mdlp_pkg::COORD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mdlp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         pixel_valid,
    output logic                         pixel_stall,
    input  mdlp_pkg::pixel_item_t        pixel,
    output logic                         color_valid,
    input  logic                         color_stall,
    output mdlp_pkg::color_item_t        color
);
    import mdlp_pkg::*;

    localparam logic [7:0] CoordMask =
        (COORD_BITS >= 8) ? 8'hFF : 8'((1 << COORD_BITS) - 1);

    logic [7:0]  image_size_reg;
    logic [7:0]  letter_code_reg;
    logic [23:0] disc_color_reg;
    logic [23:0] rim_color_reg;
    logic [23:0] letter_color_reg;
    reg_index_t  reg_index;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg   <= SIZE_RESET;
            letter_code_reg  <= CODE_RESET;
            disc_color_reg   <= '0;
            rim_color_reg    <= '0;
            letter_color_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_IMAGE_SIZE:   image_size_reg   <= pwdata[7:0];
                REG_LETTER_CODE:  letter_code_reg  <= pwdata[7:0];
                REG_DISC_COLOR:   disc_color_reg   <= pwdata[23:0];
                REG_RIM_COLOR:    rim_color_reg    <= pwdata[23:0];
                REG_LETTER_COLOR: letter_color_reg <= pwdata[23:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_IMAGE_SIZE:   prdata = {24'd0, image_size_reg};
            REG_LETTER_CODE:  prdata = {24'd0, letter_code_reg};
            REG_DISC_COLOR:   prdata = {8'd0, disc_color_reg};
            REG_RIM_COLOR:    prdata = {8'd0, rim_color_reg};
            REG_LETTER_COLOR: prdata = {8'd0, letter_color_reg};
            default:          prdata = '0;
        endcase
    end

    // Stage enables: a stage moves when it is empty or the one ahead moves.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, color_valid_reg;
    logic en1, en2, en3, en4;

    assign en4 = !color_valid_reg || !color_stall;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign pixel_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            color_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= pixel_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                color_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage 1: masked coordinates, doubled centered offsets and glyph scale.
    logic [7:0]         x_m, y_m, size_m;
    logic [16:0]        scale_prod;
    logic [7:0]         s1_x_next, s1_y_next, s1_size_next;
    logic [7:0]         s1_x_reg, s1_y_reg, s1_size_reg;
    logic signed [10:0] s1_u_next, s1_v_next, s1_u_reg, s1_v_reg;
    logic [4:0]         s1_scale_next, s1_scale_reg;
    logic               s1_in_next, s1_in_reg;

    always_comb
    begin
        x_m    = pixel.pixel_x & CoordMask;
        y_m    = pixel.pixel_y & CoordMask;
        size_m = image_size_reg & CoordMask;
        s1_x_next    = x_m;
        s1_y_next    = y_m;
        s1_size_next = size_m;
        s1_in_next   = (x_m < size_m) && (y_m < size_m);
        s1_u_next = $signed({2'b00, x_m, 1'b0}) - $signed({3'b000, size_m}) + 11'sd1;
        s1_v_next = $signed({2'b00, y_m, 1'b0}) - $signed({3'b000, size_m}) + 11'sd1;
        // Division by eleven as a reciprocal multiply, exact for eight-bit sizes.
        scale_prod    = {9'd0, size_m} * 17'd373;
        s1_scale_next = (scale_prod[16:12] == 5'd0) ? 5'd1 : scale_prod[16:12];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_x_reg     <= s1_x_next;
            s1_y_reg     <= s1_y_next;
            s1_size_reg  <= s1_size_next;
            s1_u_reg     <= s1_u_next;
            s1_v_reg     <= s1_v_next;
            s1_scale_reg <= s1_scale_next;
            s1_in_reg    <= s1_in_next;
        end
    end

    // Stage 2: squares and the glyph-relative coordinates.
    logic signed [21:0] uu_full, vv_full;
    logic [7:0]         w5, h7;
    logic signed [9:0]  dx, dy, ox, oy;
    logic [17:0]        s2_uu_next, s2_vv_next, s2_uu_reg, s2_vv_reg;
    logic [15:0]        s2_s2_next, s2_s2_reg;
    logic signed [9:0]  s2_rx_next, s2_ry_next, s2_rx_reg, s2_ry_reg;
    logic [4:0]         s2_scale_reg;
    logic               s2_in_reg;

    always_comb
    begin
        uu_full    = s1_u_reg * s1_u_reg;
        vv_full    = s1_v_reg * s1_v_reg;
        s2_uu_next = uu_full[17:0];
        s2_vv_next = vv_full[17:0];
        s2_s2_next = {8'd0, s1_size_reg} * {8'd0, s1_size_reg};
        w5 = {3'd0, s1_scale_reg} * 8'd5;
        h7 = {3'd0, s1_scale_reg} * 8'd7;
        dx = $signed({2'b00, s1_size_reg}) - $signed({2'b00, w5});
        dy = $signed({2'b00, s1_size_reg}) - $signed({2'b00, h7});
        // Halving that truncates toward zero.
        ox = (dx + $signed({9'd0, dx[9]})) >>> 1;
        oy = (dy + $signed({9'd0, dy[9]})) >>> 1;
        s2_rx_next = $signed({2'b00, s1_x_reg}) - ox;
        s2_ry_next = $signed({2'b00, s1_y_reg}) - oy;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_uu_reg    <= s2_uu_next;
            s2_vv_reg    <= s2_vv_next;
            s2_s2_reg    <= s2_s2_next;
            s2_rx_reg    <= s2_rx_next;
            s2_ry_reg    <= s2_ry_next;
            s2_scale_reg <= s1_scale_reg;
            s2_in_reg    <= s1_in_reg;
        end
    end

    // Stage 3: squared distance, and glyph cell found by comparing against
    // multiples of the scale.
    logic [9:0]  rx_u, ry_u, scale_w;
    logic        gx_in, gy_in;
    logic [18:0] s3_d_next, s3_d_reg;
    logic [15:0] s3_s2_reg;
    logic [2:0]  s3_col_next, s3_row_next, s3_col_reg, s3_row_reg;
    logic        s3_glyph_next, s3_glyph_reg;
    logic        s3_in_reg;

    always_comb
    begin
        s3_d_next = {1'b0, s2_uu_reg} + {1'b0, s2_vv_reg};
        rx_u    = {1'b0, s2_rx_reg[8:0]};
        ry_u    = {1'b0, s2_ry_reg[8:0]};
        scale_w = {5'd0, s2_scale_reg};
        gx_in   = !s2_rx_reg[9] && (rx_u < scale_w * 10'd5);
        gy_in   = !s2_ry_reg[9] && (ry_u < scale_w * 10'd7);
        s3_col_next = '0;
        s3_row_next = '0;
        for (int k = 1; k <= 4; k++)
        begin
            if (rx_u >= 10'(k) * scale_w)
            begin
                s3_col_next = s3_col_next + 3'd1;
            end
        end
        for (int k = 1; k <= 6; k++)
        begin
            if (ry_u >= 10'(k) * scale_w)
            begin
                s3_row_next = s3_row_next + 3'd1;
            end
        end
        s3_glyph_next = s2_in_reg && gx_in && gy_in;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_d_reg     <= s3_d_next;
            s3_s2_reg    <= s2_s2_reg;
            s3_col_reg   <= s3_col_next;
            s3_row_reg   <= s3_row_next;
            s3_glyph_reg <= s3_glyph_next;
            s3_in_reg    <= s2_in_reg;
        end
    end

    // Stage 4: disc and rim tests, glyph lookup and color select.
    logic [29:0]  rim_lhs, rim_rhs;
    logic         in_disc, in_rim, lit;
    logic [34:0]  rows;
    logic [4:0]   row_bits;
    logic [2:0]   col_idx;
    logic [23:0]  rgb;
    logic [7:0]   alpha_v;
    color_item_t  color_next, color_reg;

    always_comb
    begin
        rim_lhs  = {11'd0, s3_d_reg} * 30'd625;
        rim_rhs  = {14'd0, s3_s2_reg} * 30'd324;
        in_disc  = s3_in_reg && ({1'b0, s3_d_reg} <= {4'd0, s3_s2_reg});
        in_rim   = rim_lhs > rim_rhs;
        rows     = glyph_bitmap(glyph_index(letter_code_reg));
        row_bits = rows[5'd30 - {s3_row_reg, 2'b00} - {2'b00, s3_row_reg} +: 5];
        col_idx  = (s3_col_reg <= 3'd4) ? 3'd4 - s3_col_reg : 3'd0;
        lit      = s3_glyph_reg && row_bits[col_idx];
        rgb      = '0;
        alpha_v  = '0;
        if (in_disc)
        begin
            rgb     = in_rim ? rim_color_reg : disc_color_reg;
            alpha_v = OPAQUE;
        end
        if (lit)
        begin
            rgb     = letter_color_reg;
            alpha_v = OPAQUE;
        end
        color_next.red   = rgb[23:16];
        color_next.green = rgb[15:8];
        color_next.blue  = rgb[7:0];
        color_next.alpha = alpha_v;
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            color_reg <= color_next;
        end
    end

    assign color_valid = color_valid_reg;
    assign color       = color_reg;

endmodule

`default_nettype wire

[hdl/mdlp_checker.sv]
`default_nettype none

`include "marker_disc_letter_pixel_core_assert.svh"

module mdlp_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pixel_valid,
    input  logic                   pixel_stall,
    input  logic                   color_valid,
    input  logic                   color_stall,
    input  mdlp_pkg::color_item_t  color
);
    import mdlp_pkg::*;

    logic pixel_take;

    assign pixel_take = pixel_valid && !pixel_stall;

    `MDLP_ASSERT_NEXT(a_color_hold, clk, rst_n, color_valid && color_stall, color_valid && $stable(color))

    `MDLP_ASSERT_IMPL(a_alpha_code, clk, rst_n, color_valid, color.alpha == 8'd0 || color.alpha == OPAQUE)

    `MDLP_ASSERT_IMPL(a_clear_black, clk, rst_n, color_valid && color.alpha == 8'd0, color.red == 8'd0 && color.green == 8'd0 && color.blue == 8'd0)

    `MDLP_ASSERT_NEXT(a_latency, clk, rst_n, pixel_take ##1 !color_stall ##1 !color_stall ##1 !color_stall, color_valid)

endmodule

bind marker_disc_letter_pixel_core mdlp_checker u_mdlp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .color_valid (color_valid),
    .color_stall (color_stall),
    .color       (color)
);

`default_nettype wire
